### rtl/fpba_pkg.sv
// fpba_pkg: shared types and codes for the fit policy block allocator
// holds command/status structs between controller and datapath, mode and register codes
// no dependencies
`default_nettype none

package fpba_pkg;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  // fit policy codes (the unused code behaves as first fit)
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  // configuration register indexes
  localparam logic REG_FIT_MODE      = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  localparam int CFG_DATA_W      = 5;
  localparam int AMOUNT_W        = 16;
  localparam int LOAD_IDX_W      = 4;
  localparam int CHOSEN_W        = 4;
  localparam int LEFT_OVER_W     = 16;
  localparam logic [4:0] BLOCKS_IN_USE_RST = 5'd16;

  // controller to datapath
  typedef struct packed {
    logic load;    // write in_amount to the table at in_load_index
    logic start;   // capture request and clear scan state
    logic step;    // advance the table scan
    logic commit;  // charge the chosen entry and load the result register
  } fpba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // all scanned entries have been compared
    logic out_free;   // result register can take a new transaction
  } fpba_status_t;

endpackage

`default_nettype wire

### rtl/fpba_ram.sv
// fpba_ram: generic single write, single read RAM with registered read data
// no dependencies
`default_nettype none

module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/fpba_ctrl.sv
// fpba_ctrl: sequencing state machine for loads and allocation requests
// depends on fpba_pkg for command and status types
`default_nettype none

module fpba_ctrl
  import fpba_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_kind,
  output logic              in_stall,
  input  wire fpba_status_t status,
  output fpba_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   in_take;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_ALLOC) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // an accepted request always starts a scan
  a_req_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_kind == KIND_ALLOC) |=> (state_r == ST_SCAN))
    else $error("request accepted without entering scan");

endmodule

`default_nettype wire

### rtl/fpba_dp.sv
// fpba_dp: free size table, sequential scan compare, charge and result register
// depends on fpba_pkg and fpba_ram
`default_nettype none

module fpba_dp
  import fpba_pkg::*;
#(
  parameter int BLOCKS    = 16,
  parameter int SIZE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire fpba_cmd_t              cmd,
  output fpba_status_t                status,
  input  wire logic [1:0]             fit_mode,
  input  wire logic [CFG_DATA_W-1:0]  blocks_in_use,
  input  wire logic [LOAD_IDX_W-1:0]  in_load_index,
  input  wire logic [AMOUNT_W-1:0]    in_amount,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_granted,
  output logic [CHOSEN_W-1:0]         out_chosen_block,
  output logic [LEFT_OVER_W-1:0]      out_left_over
);

  localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CNT_W = $clog2(BLOCKS + 1);

  // request context
  logic [SIZE_BITS-1:0] amount_r, amount_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [1:0]           mode_r, mode_nxt;

  // scan state
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0] best_val_r, best_val_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_granted_r, out_granted_nxt;
  logic [CHOSEN_W-1:0]    out_chosen_r, out_chosen_nxt;
  logic [LEFT_OVER_W-1:0] out_left_r, out_left_nxt;

  // table ports
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [SIZE_BITS-1:0] ram_rdata;

  logic                 load_ok;
  logic                 fits;
  logic                 better;
  logic [SIZE_BITS-1:0] charged;

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (BLOCKS),
    .ADDR_W(IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(cnt_r[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign load_ok = (32'(in_load_index) < BLOCKS);
  assign charged = best_val_r - amount_r;

  // table write: either a load or the charge of the chosen entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(in_load_index);
    ram_wdata = SIZE_BITS'(in_amount);
    if (cmd.load) begin
      ram_we = load_ok;
    end else if (cmd.commit) begin
      ram_we    = found_r;
      ram_waddr = best_idx_r;
      ram_wdata = charged;
    end
  end

  // fit compare on the entry read last cycle
  always_comb begin
    fits   = (ram_rdata >= amount_r);
    better = 1'b0;
    case (mode_r)
      MODE_BEST:  better = (ram_rdata < best_val_r);
      MODE_WORST: better = (ram_rdata > best_val_r);
      default:    better = 1'b0;
    endcase
  end

  // scan sequencing and pick tracking
  always_comb begin
    amount_nxt   = amount_r;
    limit_nxt    = limit_r;
    mode_nxt     = mode_r;
    cnt_nxt      = cnt_r;
    rd_pend_nxt  = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    ram_re       = 1'b0;
    if (cmd.start) begin
      amount_nxt = SIZE_BITS'(in_amount);
      mode_nxt   = fit_mode;
      if (32'(blocks_in_use) > BLOCKS) begin
        limit_nxt = CNT_W'(BLOCKS);
      end else begin
        limit_nxt = CNT_W'(blocks_in_use);
      end
      cnt_nxt   = '0;
      found_nxt = 1'b0;
    end else if (cmd.step) begin
      if (cnt_r < limit_r) begin
        ram_re      = 1'b1;
        rd_pend_nxt = 1'b1;
        rd_idx_nxt  = cnt_r[IDX_W-1:0];
        cnt_nxt     = cnt_r + 1'b1;
      end
      if (rd_pend_r && fits && (!found_r || better)) begin
        found_nxt    = 1'b1;
        best_idx_nxt = rd_idx_r;
        best_val_nxt = ram_rdata;
      end
    end
  end

  // result register: holds a transaction until the consumer takes it
  always_comb begin
    out_valid_nxt   = out_valid_r && out_stall;
    out_granted_nxt = out_granted_r;
    out_chosen_nxt  = out_chosen_r;
    out_left_nxt    = out_left_r;
    if (cmd.commit) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = found_r;
      out_chosen_nxt  = found_r ? CHOSEN_W'(best_idx_r) : '0;
      out_left_nxt    = found_r ? LEFT_OVER_W'(charged) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amount_r      <= amount_nxt;
    limit_r       <= limit_nxt;
    mode_r        <= mode_nxt;
    rd_idx_r      <= rd_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_val_r    <= best_val_nxt;
    out_granted_r <= out_granted_nxt;
    out_chosen_r  <= out_chosen_nxt;
    out_left_r    <= out_left_nxt;
  end

  assign status.scan_done = (cnt_r >= limit_r) && !rd_pend_r;
  assign status.out_free  = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_chosen_block = out_chosen_r;
  assign out_left_over    = out_left_r;

  // every compared entry lies inside the scan window
  a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (32'(rd_idx_r) < 32'(limit_r)))
    else $error("table read outside the scan window");

  // a granted pick lies inside the window and covers the request
  a_pick_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && found_r) |-> (32'(best_idx_r) < 32'(limit_r)))
    else $error("chosen block outside the scan window");

  a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && found_r) |-> (best_val_r >= amount_r))
    else $error("chosen block smaller than the request");

endmodule

`default_nettype wire

### rtl/fit_policy_block_allocator.sv
// fit_policy_block_allocator: first, best and worst fit allocator over a table of free sizes
// a load transaction gives no result
// a request scans N = min(blocks_in_use, BLOCKS) table entries before its result is written out:
// N table reads, one compare of the last entry read, a step to close the scan, one write back
// the input stalls from a request's acceptance until its result is written; a held result stalls no load
// reset is synchronous active low: config returns to first fit over 16 blocks, table is not cleared
`default_nettype none

module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int BLOCKS    = 16,
  parameter int SIZE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration port
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_kind,
  input  wire logic [LOAD_IDX_W-1:0] in_load_index,
  input  wire logic [AMOUNT_W-1:0]   in_amount,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_granted,
  output logic [CHOSEN_W-1:0]        out_chosen_block,
  output logic [LEFT_OVER_W-1:0]     out_left_over
);

  logic [1:0]            fit_mode_r;
  logic [CFG_DATA_W-1:0] blocks_in_use_r;
  fpba_cmd_t             cmd;
  fpba_status_t          status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r      <= MODE_FIRST;
      blocks_in_use_r <= BLOCKS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIT_MODE:      fit_mode_r      <= cfg_data[1:0];
        REG_BLOCKS_IN_USE: blocks_in_use_r <= cfg_data;
        default:           fit_mode_r      <= fit_mode_r;
      endcase
    end
  end

  fpba_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_kind (in_kind),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  fpba_dp #(
    .BLOCKS   (BLOCKS),
    .SIZE_BITS(SIZE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .fit_mode        (fit_mode_r),
    .blocks_in_use   (blocks_in_use_r),
    .in_load_index   (in_load_index),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_granted     (out_granted),
    .out_chosen_block(out_chosen_block),
    .out_left_over   (out_left_over)
  );

endmodule

`default_nettype wire

### sim/tb_fit_policy_block_allocator.sv
// tb_fit_policy_block_allocator: self-checking testbench for the fit policy block allocator
// drives load and request transactions, predicts first/best/worst fit grants, checks results
// depends on rtl/fpba_pkg.sv and rtl/fit_policy_block_allocator.sv
`timescale 1ns / 1ps

module tb_fit_policy_block_allocator;
  import fpba_pkg::*;

  localparam int BLOCKS           = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES     = 24;
  localparam int QUIET_LIMIT      = 4000;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 154;

  typedef struct packed {
    logic                  kind;
    logic [LOAD_IDX_W-1:0] load_index;
    logic [AMOUNT_W-1:0]   amount;
  } alloc_item_t;

  typedef struct packed {
    logic                   granted;
    logic [CHOSEN_W-1:0]    chosen_block;
    logic [LEFT_OVER_W-1:0] left_over;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_FIT_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = KIND_LOAD;
  logic [LOAD_IDX_W-1:0] in_load_index = '0;
  logic [AMOUNT_W-1:0] in_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_granted;
  logic [CHOSEN_W-1:0] out_chosen_block;
  logic [LEFT_OVER_W-1:0] out_left_over;

  // stimulus and scoreboard state
  alloc_item_t   pending_q [$];
  alloc_item_t   cur_item;
  alloc_result_t grant_q [$];
  logic [AMOUNT_W-1:0]   free_sizes [BLOCKS];
  logic [1:0]            mode_shadow = MODE_FIRST;
  logic [CFG_DATA_W-1:0] blocks_shadow = BLOCKS_IN_USE_RST;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int loads_sent = 0;
  int requests_sent = 0;
  int grants_seen = 0;
  int results_seen = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  fit_policy_block_allocator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_load_index    (in_load_index),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted      (out_granted),
    .out_chosen_block (out_chosen_block),
    .out_left_over    (out_left_over)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // update the free size table for one transaction and, for a request, queue the expected grant
  function automatic void charge_free_table(alloc_item_t item);
    int unsigned scan_len;
    logic found;
    int pick;
    alloc_result_t res;
    if (item.kind == KIND_LOAD) begin
      free_sizes[item.load_index] = item.amount;
      return;
    end
    scan_len = (blocks_shadow > BLOCKS) ? BLOCKS : blocks_shadow;
    found = 1'b0;
    pick = 0;
    for (int i = 0; i < scan_len; i++) begin
      if (free_sizes[i] >= item.amount) begin
        if (!found) begin
          found = 1'b1;
          pick = i;
          // first fit and the unused code stop at the first fitting block
          if (mode_shadow != MODE_BEST && mode_shadow != MODE_WORST)
            break;
        end else if (mode_shadow == MODE_BEST && free_sizes[i] < free_sizes[pick]) begin
          pick = i;
        end else if (mode_shadow == MODE_WORST && free_sizes[i] > free_sizes[pick]) begin
          pick = i;
        end
      end
    end
    res = '0;
    if (found) begin
      free_sizes[pick] = free_sizes[pick] - item.amount;
      res.granted = 1'b1;
      res.chosen_block = pick[CHOSEN_W-1:0];
      res.left_over = free_sizes[pick];
    end
    grant_q.push_back(res);
  endfunction

  function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // random transaction: mostly requests of varied sizes, loads refill the table
  function automatic alloc_item_t make_item();
    alloc_item_t item;
    int unsigned r;
    int unsigned s;
    r = $urandom_range(99);
    s = $urandom_range(99);
    item.load_index = LOAD_IDX_W'($urandom);
    if (r < 32) begin
      item.kind = KIND_LOAD;
      if (s < 20)      item.amount = AMOUNT_W'($urandom);
      else if (s < 30) item.amount = (s[0]) ? '1 : '0;
      else if (s < 55) item.amount = AMOUNT_W'(64 << $urandom_range(0, 4));
      else             item.amount = AMOUNT_W'($urandom_range(0, 8191));
    end else begin
      item.kind = KIND_ALLOC;
      if (s < 10)      item.amount = '0;
      else if (s < 18) item.amount = '1;
      else if (s < 28) item.amount = AMOUNT_W'($urandom);
      else if (s < 40) item.amount = AMOUNT_W'(64 << $urandom_range(0, 4));
      else             item.amount = AMOUNT_W'($urandom_range(0, 2047));
    end
    return item;
  endfunction

  task automatic queue_item(input logic kind, input int unsigned idx, input int unsigned amt);
    alloc_item_t item;
    item.kind = kind;
    item.load_index = LOAD_IDX_W'(idx);
    item.amount = AMOUNT_W'(amt);
    pending_q.push_back(item);
  endtask

  // wait until every transaction is accepted and every grant has arrived
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || grant_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FIT_MODE) mode_shadow = val[1:0];
    else blocks_shadow = val;
  endtask

  task automatic set_regs(input logic [1:0] mode, input logic [CFG_DATA_W-1:0] count);
    wait_idle();
    write_reg(REG_FIT_MODE, CFG_DATA_W'(mode));
    write_reg(REG_BLOCKS_IN_USE, count);
    settings_used++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        charge_free_table(cur_item);
        if (cur_item.kind == KIND_LOAD) loads_sent++;
        else requests_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= cur_item.kind;
          in_load_index <= cur_item.load_index;
          in_amount <= cur_item.amount;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_granted) grants_seen++;
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual granted %0d block %0d left %0d",
                   $time, out_granted, out_chosen_block, out_left_over);
          error_count++;
        end else begin
          exp_res = grant_q.pop_front();
          check_field("granted", exp_res.granted, out_granted);
          check_field("chosen_block", exp_res.chosen_block, out_chosen_block);
          check_field("left_over", exp_res.left_over, out_left_over);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // count cycles with no transaction on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    logic [CFG_DATA_W-1:0] count;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_regs(MODE_FIRST, CFG_DATA_W'(BLOCKS));

    // fill every entry first so no request scans an unwritten one
    for (int i = 0; i < BLOCKS; i++) begin
      if (i == 1 || i == 6)      queue_item(KIND_LOAD, i, 65535);
      else if (i == 2)           queue_item(KIND_LOAD, i, 0);
      else if (i == 3 || i == 4) queue_item(KIND_LOAD, i, 40);
      else                       queue_item(KIND_LOAD, i, i * 1000 + 1);
    end
    // zero request, full size request, plain first fit
    queue_item(KIND_ALLOC, 15, 0);
    queue_item(KIND_ALLOC, 0, 65535);
    queue_item(KIND_ALLOC, 9, 50);
    // best fit tie goes to the lower index
    set_regs(MODE_BEST, CFG_DATA_W'(BLOCKS));
    queue_item(KIND_ALLOC, 0, 40);
    set_regs(MODE_WORST, CFG_DATA_W'(BLOCKS));
    queue_item(KIND_ALLOC, 0, 1);
    // unused mode acts as first fit
    set_regs(MODE_UNUSED, CFG_DATA_W'(BLOCKS));
    queue_item(KIND_ALLOC, 0, 7);
    // empty scan never grants
    set_regs(MODE_FIRST, '0);
    queue_item(KIND_ALLOC, 0, 0);
    // scan length beyond the table saturates
    set_regs(MODE_WORST, '1);
    queue_item(KIND_ALLOC, 0, 2);
    set_regs(MODE_BEST, CFG_DATA_W'(1));
    queue_item(KIND_ALLOC, 0, 65535);

    // random phases over policies, scan lengths and idle profiles
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 6:    count = CFG_DATA_W'(BLOCKS);
        2:       count = '1;
        3:       count = CFG_DATA_W'(1);
        4:       count = CFG_DATA_W'(BLOCKS + 1);
        5:       count = CFG_DATA_W'($urandom_range(2, BLOCKS - 1));
        default: count = CFG_DATA_W'($urandom_range(1, BLOCKS));
      endcase
      set_regs(2'(p % 4), count);
      case ((p >> 1) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        pending_q.push_back(make_item());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d loads and %0d requests (%0d granted, %0d results checked)",
             loads_sent, requests_sent, grants_seen, results_seen);
    $display("over %0d register settings with all four fit codes and mixed idling",
             settings_used);
    if (error_count == 0 && grant_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count, grant_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
